### hw/rtl/gmr_pkg.sv
// Gathered matrix rotation: shared types and constants.
// Used by gmr_store, gmr_mac and gathered_matrix_rotation; no dependencies.
`default_nettype none

package gmr_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MO_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_COUNT = 2'd1;

    localparam logic [1:0] OP_LOAD_ROT  = 2'd0;
    localparam logic [1:0] OP_LOAD_SEL  = 2'd1;
    localparam logic [1:0] OP_LOAD_COEF = 2'd2;
    localparam logic [1:0] OP_COMPUTE   = 2'd3;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         row;
        logic [7:0]         col;
        logic signed [31:0] value;
        logic [5:0]         select;
    } cmd_t;

    typedef struct packed {
        logic [5:0]         out_row;
        logic [7:0]         out_col;
        logic signed [31:0] result;
        logic               overflow;
    } rsp_t;

    // read request from the sequencer to the stores
    typedef struct packed {
        logic       issue;
        logic       first;
        logic       last;
        logic [5:0] row;
        logic [7:0] col;
    } gather_t;

    // term flags travelling alongside the operand data
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic live;
    } term_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] result;
        logic               overflow;
    } mac_out_t;

endpackage

`default_nettype wire

### hw/rtl/gmr_store.sv
// Rotation, selection and coefficient memories with the two-step gather read.
// Depends on gmr_pkg.
`default_nettype none

module gmr_store #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire gmr_pkg::cmd_t               cmd,
    input  wire gmr_pkg::gather_t            gather,
    input  wire logic [$clog2(MAX_ROWS)-1:0] k,
    output gmr_pkg::term_t                   term,
    output logic signed [31:0]               rot_data,
    output logic signed [31:0]               coef_data
);
    import gmr_pkg::*;

    localparam int unsigned ROT_DEPTH  = MAX_ROWS * MAX_ROWS;
    localparam int unsigned COEF_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned ROT_AW     = $clog2(ROT_DEPTH);
    localparam int unsigned COEF_AW    = $clog2(COEF_DEPTH);
    localparam int unsigned RW         = $clog2(MAX_ROWS);

    logic signed [31:0] rot_mem  [ROT_DEPTH];
    logic [5:0]         sel_mem  [MAX_ROWS];
    logic signed [31:0] coef_mem [COEF_DEPTH];

    logic               rot_we;
    logic               sel_we;
    logic               coef_we;
    logic [ROT_AW-1:0]  rot_waddr;
    logic [ROT_AW-1:0]  rot_raddr;
    logic [COEF_AW-1:0] coef_waddr;
    logic [COEF_AW-1:0] coef_raddr;

    logic [5:0]         sel_reg;
    logic signed [31:0] rot_reg;
    logic signed [31:0] rot_dly_reg;
    logic signed [31:0] coef_reg;
    term_t              s1_reg;
    term_t              s1_next;
    term_t              s2_reg;
    term_t              s2_next;

    always_comb
    begin
        rot_we  = load && (cmd.opcode == OP_LOAD_ROT) && (32'(cmd.row) < MAX_ROWS)
                  && (32'(cmd.col) < MAX_ROWS);
        sel_we  = load && (cmd.opcode == OP_LOAD_SEL) && (32'(cmd.row) < MAX_ROWS);
        coef_we = load && (cmd.opcode == OP_LOAD_COEF) && (32'(cmd.row) < MAX_ROWS)
                  && (32'(cmd.col) < MAX_COLS);

        rot_waddr  = ROT_AW'(cmd.row) * ROT_AW'(MAX_ROWS) + ROT_AW'(cmd.col);
        rot_raddr  = ROT_AW'(gather.row) * ROT_AW'(MAX_ROWS) + ROT_AW'(k);
        coef_waddr = COEF_AW'(cmd.row) * COEF_AW'(MAX_COLS) + COEF_AW'(cmd.col);
        coef_raddr = COEF_AW'(sel_reg) * COEF_AW'(MAX_COLS) + COEF_AW'(gather.col);

        s1_next       = '0;
        s1_next.valid = gather.issue;
        s1_next.first = gather.first;
        s1_next.last  = gather.last;

        s2_next      = s1_reg;
        s2_next.live = (32'(sel_reg) < MAX_ROWS);
    end

    always_ff @(posedge clk)
    begin
        if (rot_we)
        begin
            rot_mem[rot_waddr] <= cmd.value;
        end
        if (gather.issue)
        begin
            rot_reg <= rot_mem[rot_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_we)
        begin
            sel_mem[RW'(cmd.row)] <= cmd.select;
        end
        if (gather.issue)
        begin
            sel_reg <= sel_mem[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= cmd.value;
        end
        if (s1_reg.valid)
        begin
            coef_reg <= coef_mem[coef_raddr];
        end
    end

    // keep the rotation operand aligned with the gathered coefficient
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            rot_dly_reg <= rot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign term      = s2_reg;
    assign rot_data  = rot_dly_reg;
    assign coef_data = coef_reg;

endmodule

`default_nettype wire

### hw/rtl/gmr_mac.sv
// Multiply-accumulate with Q16.16 rounding and saturation.
// Depends on gmr_pkg.
`default_nettype none

module gmr_mac #(
    parameter int unsigned MAX_ROWS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gmr_pkg::term_t     term,
    input  wire logic signed [31:0] rot_data,
    input  wire logic signed [31:0] coef_data,
    output gmr_pkg::mac_out_t       mac_out
);
    import gmr_pkg::*;

    localparam int unsigned ACC_W = 64 + $clog2(MAX_ROWS);
    localparam int unsigned SHF_W = ACC_W - 16;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(32'h0000_8000);

    logic signed [63:0]      prod_next;
    logic signed [63:0]      prod_reg;
    term_t                   pflag_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    fin_reg;
    logic signed [ACC_W-1:0] rounded;
    logic [SHF_W-1:0]        shifted;
    logic [SHF_W-32:0]       high_bits;
    logic                    fits;
    mac_out_t                out_next;
    mac_out_t                out_reg;

    always_comb
    begin
        prod_next = term.live ? rot_data * coef_data : 64'sd0;
        acc_next  = pflag_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

        rounded   = acc_reg + HALF_LSB;
        shifted   = rounded[ACC_W-1:16];
        high_bits = shifted[SHF_W-1:31];
        fits      = (&high_bits) || !(|high_bits);

        out_next.valid    = fin_reg;
        out_next.overflow = !fits;
        if (fits)
        begin
            out_next.result = shifted[31:0];
        end
        else if (shifted[SHF_W-1])
        begin
            out_next.result = SAT_MIN;
        end
        else
        begin
            out_next.result = SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (term.valid)
        begin
            prod_reg <= prod_next;
        end
        if (pflag_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pflag_reg <= '0;
            fin_reg   <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            pflag_reg <= term;
            fin_reg   <= pflag_reg.valid && pflag_reg.last;
            out_reg   <= out_next;
        end
    end

    assign mac_out = out_reg;

endmodule

`default_nettype wire

### hw/rtl/gathered_matrix_rotation.sv
// Gathered matrix rotation top: configuration, sequencer, gmr_store and gmr_mac; uses gmr_pkg.
// Loads are written when accepted and do not make the block busy. A compute in range, with
// n = mo_count capped at MAX_ROWS, issues one memory read per term for its n terms, passes
// them through the store and MAC registers, transfers its result and only then takes the next
// command. Out-of-range computes give no result. The receiver cannot stall.
// Reset is asynchronous: counts return to 1, memory contents stay undefined.
`default_nettype none

module gathered_matrix_rotation #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [gmr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gmr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              start,
    input  wire gmr_pkg::cmd_t                     cmd,
    output logic                                   busy,
    output logic                                   done,
    output gmr_pkg::rsp_t                          rsp
);
    import gmr_pkg::*;

    localparam int unsigned RW  = $clog2(MAX_ROWS);
    localparam int unsigned N_W = $clog2(MAX_ROWS + 1);
    localparam int unsigned F_W = $clog2(MAX_COLS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t        state_reg;
    logic [RW-1:0] k_reg;
    logic [5:0]    row_reg;
    logic [7:0]    col_reg;
    logic [6:0]    mo_count_reg;
    logic [8:0]    func_count_reg;

    logic [N_W-1:0] nmo;
    logic [F_W-1:0] nf;
    logic           accept;
    logic           in_range;
    logic           k_last;
    gather_t        gather;
    term_t          term;
    logic signed [31:0] rot_data;
    logic signed [31:0] coef_data;
    mac_out_t       mac_out;

    always_comb
    begin
        nmo = (32'(mo_count_reg) > MAX_ROWS) ? N_W'(MAX_ROWS) : N_W'(mo_count_reg);
        nf  = (32'(func_count_reg) > MAX_COLS) ? F_W'(MAX_COLS) : F_W'(func_count_reg);

        accept   = start && !busy;
        in_range = (32'(cmd.row) < 32'(nmo)) && (32'(cmd.col) < 32'(nf));
        k_last   = (32'(k_reg) + 32'd1 == 32'(nmo));

        gather.issue = (state_reg == ST_ISSUE);
        gather.first = (k_reg == '0);
        gather.last  = k_last;
        gather.row   = row_reg;
        gather.col   = col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mo_count_reg   <= 7'd1;
            func_count_reg <= 9'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MO_COUNT:   mo_count_reg   <= cfg_data[6:0];
                CFG_FUNC_COUNT: func_count_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (cmd.opcode == OP_COMPUTE) && in_range)
                    begin
                        state_reg <= ST_ISSUE;
                        k_reg     <= '0;
                        row_reg   <= cmd.row;
                        col_reg   <= cmd.col;
                    end
                end
                ST_ISSUE:
                begin
                    if (k_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + RW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (mac_out.valid)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    gmr_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .cmd       (cmd),
        .gather    (gather),
        .k         (k_reg),
        .term      (term),
        .rot_data  (rot_data),
        .coef_data (coef_data)
    );

    gmr_mac #(
        .MAX_ROWS (MAX_ROWS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .term      (term),
        .rot_data  (rot_data),
        .coef_data (coef_data),
        .mac_out   (mac_out)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = mac_out.valid;

    always_comb
    begin
        rsp.out_row  = row_reg;
        rsp.out_col  = col_reg;
        rsp.result   = mac_out.result;
        rsp.overflow = mac_out.overflow;
    end

`ifndef SYNTHESIS
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_DRAIN))
        else $error("result strobe outside drain");

    a_compute_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.opcode == OP_COMPUTE) && in_range) |=> busy)
        else $error("accepted compute did not start");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mac_out.valid)
        else $error("result produced while idle");

    a_term_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (32'(k_reg) < 32'(nmo)))
        else $error("term index beyond row count");

    a_issue_to_term: assert property (@(posedge clk) disable iff (!rst_n)
        gather.issue |-> ##2 term.valid)
        else $error("gather read lost in store pipeline");
`endif

endmodule

`default_nettype wire
